FILE: sv/stl_pkg.sv
// Package with scanner modes, token kinds, error codes and character helpers.
`timescale 1ns / 1ps
package stl_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_IDENT  = 4'd1,
    MODE_NUMBER = 4'd2,
    MODE_STRING = 4'd3,
    MODE_CHAR   = 4'd4,
    MODE_OP     = 4'd5,
    MODE_LINE   = 4'd6,
    MODE_BLOCK  = 4'd7,
    MODE_STAR   = 4'd8,
    MODE_HALT   = 4'd9
  } scan_mode_e;

  localparam logic [5:0] KIND_IDENT  = 6'd0;
  localparam logic [5:0] KIND_INT    = 6'd1;
  localparam logic [5:0] KIND_LONG   = 6'd2;
  localparam logic [5:0] KIND_FLOAT  = 6'd3;
  localparam logic [5:0] KIND_DOUBLE = 6'd4;
  localparam logic [5:0] KIND_SHORT  = 6'd5;
  localparam logic [5:0] KIND_STR    = 6'd6;
  localparam logic [5:0] KIND_CHR    = 6'd7;
  localparam logic [5:0] KIND_ERROR  = 6'd45;
  localparam logic [5:0] KIND_NONE   = 6'd63;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DOUBLE_DOT = 3'd1;
  localparam logic [2:0] ERR_OPEN_STR  = 3'd2;
  localparam logic [2:0] ERR_OPEN_CHR  = 3'd3;
  localparam logic [2:0] ERR_CHR_LEN   = 3'd4;
  localparam logic [2:0] ERR_BAD_OP    = 3'd5;
  localparam logic [2:0] ERR_OPEN_CMT  = 3'd6;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Returns KIND_NONE for a byte that is no operator.
  function automatic logic [5:0] single_op(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      8'h2B: k = 6'd20;
      8'h2D: k = 6'd21;
      8'h2A: k = 6'd22;
      8'h2F: k = 6'd23;
      8'h25: k = 6'd24;
      8'h3D: k = 6'd25;
      8'h21: k = 6'd28;
      8'h3E: k = 6'd29;
      8'h3C: k = 6'd31;
      8'h2E: k = 6'd35;
      8'h2C: k = 6'd36;
      8'h3B: k = 6'd37;
      8'h3A: k = 6'd38;
      8'h28: k = 6'd39;
      8'h29: k = 6'd40;
      8'h7B: k = 6'd41;
      8'h7D: k = 6'd42;
      8'h5B: k = 6'd43;
      8'h5D: k = 6'd44;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_op(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = KIND_NONE;
    if (a == 8'h3D && b == 8'h3D) k = 6'd26;
    if (a == 8'h21 && b == 8'h3D) k = 6'd27;
    if (a == 8'h3E && b == 8'h3D) k = 6'd30;
    if (a == 8'h3C && b == 8'h3D) k = 6'd32;
    if (a == 8'h26 && b == 8'h26) k = 6'd33;
    if (a == 8'h7C && b == 8'h7C) k = 6'd34;
    return k;
  endfunction

endpackage

FILE: sv/stl_keyword.sv
// Keyword matcher over the six-byte identifier buffer.
`timescale 1ns / 1ps
module stl_keyword (
  input  logic [47:0] buf_i,
  input  logic [2:0]  len_i,
  input  logic        overflow_i,
  output logic [5:0]  kind_o
);
  import stl_pkg::*;

  function automatic logic hit(input logic [47:0] b, input logic [2:0] l,
                               input logic [47:0] w, input logic [2:0] wl);
    return l == wl && b == w;
  endfunction

  always_comb begin
    kind_o = KIND_IDENT;
    if (!overflow_i) begin
      if (hit(buf_i, len_i, 48'h0000_6575_7274, 3'd4)) kind_o = 6'd8;
      if (hit(buf_i, len_i, 48'h0065_736c_6166, 3'd5)) kind_o = 6'd8;
      if (hit(buf_i, len_i, 48'h0000_6c6f_6f62, 3'd4)) kind_o = 6'd9;
      if (hit(buf_i, len_i, 48'h0000_7261_6863, 3'd4)) kind_o = 6'd10;
      if (hit(buf_i, len_i, 48'h0000_0036_3169, 3'd3)) kind_o = 6'd11;
      if (hit(buf_i, len_i, 48'h0000_0032_3369, 3'd3)) kind_o = 6'd12;
      if (hit(buf_i, len_i, 48'h0000_0034_3669, 3'd3)) kind_o = 6'd13;
      if (hit(buf_i, len_i, 48'h0000_0032_3366, 3'd3)) kind_o = 6'd14;
      if (hit(buf_i, len_i, 48'h0000_0034_3666, 3'd3)) kind_o = 6'd15;
      if (hit(buf_i, len_i, 48'h0000_0074_656c, 3'd3)) kind_o = 6'd16;
      if (hit(buf_i, len_i, 48'h0000_006e_7566, 3'd3)) kind_o = 6'd17;
      if (hit(buf_i, len_i, 48'h6e72_7574_6572, 3'd6)) kind_o = 6'd18;
      if (hit(buf_i, len_i, 48'h0074_736e_6f63, 3'd5)) kind_o = 6'd19;
    end
  end

endmodule

FILE: sv/source_text_lexer.sv
// Top level: byte-serial lexical scanner with registered token output.
// A token is registered from the byte that ends it, into the skid if stalled.
// Throughput: one byte or end marker per cycle while the skid is empty; the
// output register and one-word skid keep input accepting while one token waits.
// Reset: asynchronous, active low; clears mode, counters and output valid.
// After an error token the scanner drops all input until reset.
`timescale 1ns / 1ps
module source_text_lexer #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // source_char
  input  logic s_axis_tlast,        // end_of_source
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata fields from bit 0: token_kind, error_code, start_offset, end_offset,
  // start_line, start_column (zero padded to bytes)
  output logic [((9 + 2*OFFSET_BITS + LINE_BITS + COLUMN_BITS + 7)/8)*8-1:0] m_axis_tdata
);
  import stl_pkg::*;

  localparam int PayW = 9 + 2*OFFSET_BITS + LINE_BITS + COLUMN_BITS;
  localparam int DataW = ((PayW + 7) / 8) * 8;
  localparam logic [LINE_BITS-1:0]   LineMax = '1;
  localparam logic [COLUMN_BITS-1:0] ColMax  = '1;

  scan_mode_e mode_q, mode_d;
  logic [47:0] kbuf_q, kbuf_d;
  logic [2:0]  klen_q, klen_d;
  logic        kovf_q, kovf_d;
  logic        dot_q, dot_d;
  logic [7:0]  pend_q, pend_d;
  logic [1:0]  ccnt_q, ccnt_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, tso_q, tso_d;
  logic [LINE_BITS-1:0]   line_q, line_d, tsl_q, tsl_d;
  logic [COLUMN_BITS-1:0] col_q, col_d, tsc_q, tsc_d;

  logic [PayW-1:0] out_q, skid_q, pay;
  logic out_vld_q, skid_vld_q;
  logic take, emit_valid;
  logic [5:0] kw_kind, e_kind, sop;
  logic [2:0] e_err;
  logic [OFFSET_BITS-1:0] e_end, pos_inc;
  logic [7:0] c;
  logic restart;

  stl_keyword u_kw (.buf_i(kbuf_q), .len_i(klen_q), .overflow_i(kovf_q), .kind_o(kw_kind));

  assign s_axis_tready = !skid_vld_q;
  assign take = s_axis_tvalid && s_axis_tready;
  assign c = s_axis_tdata;
  assign pos_inc = pos_q + 1'b1;
  assign sop = single_op(pend_q);

  always_comb begin
    mode_d = mode_q; kbuf_d = kbuf_q; klen_d = klen_q; kovf_d = kovf_q;
    dot_d = dot_q; pend_d = pend_q; ccnt_d = ccnt_q;
    pos_d = pos_q; line_d = line_q; col_d = col_q;
    tso_d = tso_q; tsl_d = tsl_q; tsc_d = tsc_q;
    emit_valid = 1'b0; e_kind = KIND_IDENT; e_err = ERR_NONE; e_end = pos_q;
    restart = 1'b0;
    if (take && mode_q != MODE_HALT) begin
      if (s_axis_tlast) begin
        emit_valid = 1'b1;
        unique case (mode_q)
          MODE_IDENT:  e_kind = kw_kind;
          MODE_NUMBER: e_kind = dot_q ? KIND_DOUBLE : KIND_INT;
          MODE_STRING: e_err = ERR_OPEN_STR;
          MODE_CHAR:   e_err = ERR_OPEN_CHR;
          MODE_OP:     if (sop == KIND_NONE) e_err = ERR_BAD_OP; else e_kind = sop;
          MODE_BLOCK, MODE_STAR: e_err = ERR_OPEN_CMT;
          default:     emit_valid = 1'b0;
        endcase
        if (e_err != ERR_NONE) begin
          e_kind = KIND_ERROR; mode_d = MODE_HALT;
        end else begin
          mode_d = MODE_IDLE; pos_d = '0;
          line_d = LINE_BITS'(1); col_d = COLUMN_BITS'(1);
        end
      end else begin
        unique case (mode_q)
          MODE_IDLE: restart = 1'b1;
          MODE_IDENT:
            if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
              if (klen_q < 3'd6) begin
                kbuf_d = kbuf_q | (48'(c) << {klen_q, 3'b000});
                klen_d = klen_q + 1'b1;
              end else kovf_d = 1'b1;
            end else begin
              emit_valid = 1'b1; e_kind = kw_kind; restart = 1'b1;
            end
          MODE_NUMBER:
            if (is_digit(c)) begin
            end else if (c == CH_DOT) begin
              if (dot_q) begin
                emit_valid = 1'b1; e_kind = KIND_ERROR; e_err = ERR_DOUBLE_DOT;
              end else dot_d = 1'b1;
            end else if ((c | 8'h20) == 8'h6C || (c | 8'h20) == 8'h66
                         || (c | 8'h20) == 8'h73) begin
              emit_valid = 1'b1; mode_d = MODE_IDLE;
              e_kind = ((c | 8'h20) == 8'h6C) ? KIND_LONG :
                       ((c | 8'h20) == 8'h66) ? KIND_FLOAT : KIND_SHORT;
            end else begin
              emit_valid = 1'b1; e_kind = dot_q ? KIND_DOUBLE : KIND_INT; restart = 1'b1;
            end
          MODE_STRING:
            if (c == CH_DQUOTE) begin
              emit_valid = 1'b1; e_kind = KIND_STR; mode_d = MODE_IDLE;
            end
          MODE_CHAR:
            if (c == CH_SQUOTE) begin
              emit_valid = 1'b1;
              if (ccnt_q != 2'd1) begin
                e_kind = KIND_ERROR; e_err = ERR_CHR_LEN;
              end else begin
                e_kind = KIND_CHR; mode_d = MODE_IDLE;
              end
            end else if (ccnt_q < 2'd2) ccnt_d = ccnt_q + 1'b1;
          MODE_OP:
            if (pair_op(pend_q, c) != KIND_NONE) begin
              emit_valid = 1'b1; e_kind = pair_op(pend_q, c); e_end = pos_inc;
              mode_d = MODE_IDLE;
            end else if (pend_q == CH_SLASH && c == CH_SLASH) mode_d = MODE_LINE;
            else if (pend_q == CH_SLASH && c == CH_STAR) mode_d = MODE_BLOCK;
            else begin
              emit_valid = 1'b1;
              if (sop == KIND_NONE) begin
                e_kind = KIND_ERROR; e_err = ERR_BAD_OP;
              end else begin
                e_kind = sop; restart = 1'b1;
              end
            end
          MODE_LINE:  if (c == CH_NL) mode_d = MODE_IDLE;
          MODE_BLOCK: if (c == CH_STAR) mode_d = MODE_STAR;
          MODE_STAR:
            if (c == CH_SLASH) mode_d = MODE_IDLE;
            else if (c != CH_STAR) mode_d = MODE_BLOCK;
          default: mode_d = MODE_HALT;
        endcase
        if (e_err != ERR_NONE) begin
          mode_d = MODE_HALT; restart = 1'b0;
        end else begin
          if (restart) begin
            mode_d = MODE_IDLE;
            if (is_space(c)) begin
            end else if (is_digit(c)) begin
              mode_d = MODE_NUMBER; dot_d = 1'b0;
              tso_d = pos_q; tsl_d = line_q; tsc_d = col_q;
            end else if (is_alpha(c) || c == CH_UNDER) begin
              mode_d = MODE_IDENT; kbuf_d = 48'(c); klen_d = 3'd1; kovf_d = 1'b0;
              tso_d = pos_q; tsl_d = line_q; tsc_d = col_q;
            end else if (c == CH_DQUOTE) begin
              mode_d = MODE_STRING; tso_d = pos_inc; tsl_d = line_q; tsc_d = col_q;
            end else if (c == CH_SQUOTE) begin
              mode_d = MODE_CHAR; ccnt_d = 2'd0;
              tso_d = pos_inc; tsl_d = line_q; tsc_d = col_q;
            end else begin
              mode_d = MODE_OP; pend_d = c;
              tso_d = pos_q; tsl_d = line_q; tsc_d = col_q;
            end
          end
          // advance position counters
          pos_d = pos_inc;
          if (c == CH_NL) begin
            col_d = COLUMN_BITS'(1);
            if (line_q != LineMax) line_d = line_q + 1'b1;
          end else if (col_q != ColMax) col_d = col_q + 1'b1;
        end
      end
    end
  end

  assign pay = {tsc_q, tsl_q, e_end, tso_q, e_err, e_kind};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; kbuf_q <= '0; klen_q <= '0; kovf_q <= 1'b0;
      dot_q <= 1'b0; pend_q <= '0; ccnt_q <= '0;
      pos_q <= '0; line_q <= LINE_BITS'(1); col_q <= COLUMN_BITS'(1);
      tso_q <= '0; tsl_q <= LINE_BITS'(1); tsc_q <= COLUMN_BITS'(1);
      out_vld_q <= 1'b0; skid_vld_q <= 1'b0;
    end else begin
      mode_q <= mode_d; kbuf_q <= kbuf_d; klen_q <= klen_d; kovf_q <= kovf_d;
      dot_q <= dot_d; pend_q <= pend_d; ccnt_q <= ccnt_d;
      pos_q <= pos_d; line_q <= line_d; col_q <= col_d;
      tso_q <= tso_d; tsl_q <= tsl_d; tsc_q <= tsc_d;
      // output register with one-word skid
      if (!out_vld_q || m_axis_tready) begin
        if (skid_vld_q) begin
          out_vld_q <= 1'b1; skid_vld_q <= 1'b0;
        end else out_vld_q <= emit_valid;
      end else if (emit_valid) skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : pay;
    end else if (emit_valid) skid_q <= pay;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = DataW'(out_q);

`ifndef NO_ASSERTIONS
  a_skid_only_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid word without output word");
  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_HALT |=> mode_q == MODE_HALT) else $error("left halt without reset");
  a_no_emit_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_HALT |-> !emit_valid) else $error("token while halted");
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !m_axis_tready |=> skid_vld_q) else $error("skid word lost");
`endif

endmodule
